// ----- hdl/lsfb_pkg.sv -----
// Shared types, constants and the per-channel fade step for the LED strip controller.
`default_nettype none

package lsfb_pkg;

  localparam int MaxLeds = 32;
  localparam int AddrW   = (MaxLeds > 1) ? $clog2(MaxLeds) : 1;
  localparam int CntW    = $clog2(MaxLeds + 1);
  localparam int IdxW    = 5;
  localparam int ChanW   = 8;
  localparam int WordW   = 24;
  localparam int CfgIdxW = 1;
  localparam int CfgDatW = 6;

  localparam logic [CntW-1:0] ResetCount = CntW'((MaxLeds < 15) ? MaxLeds : 15);

  typedef enum logic [0:0] {
    CMD_WRITE   = 1'b0,
    CMD_REFRESH = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FADE_ENABLE = 1'b0,
    REG_LED_COUNT   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  localparam rgb_t SetpointInit = '{r: 8'd10, g: 8'd30, b: 8'd170};

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    rgb_t             data;
  } mem_wr_t;

  // diff/10 and diff/20 for diff < 256 via x*205 >> 11 (resp. 12)
  localparam logic [ChanW-1:0] RecipTen = 8'd205;
  localparam int FallShift = 11;
  localparam int RiseShift = 12;

  function automatic logic [ChanW-1:0] step_chan(input logic [ChanW-1:0] now,
                                                 input logic [ChanW-1:0] goal);
    logic             rising;
    logic [ChanW-1:0] diff;
    logic [15:0]      prod;
    logic [ChanW-1:0] delta;
    rising = now < goal;
    diff   = rising ? (goal - now) : (now - goal);
    prod   = {8'd0, diff} * {8'd0, RecipTen};
    delta  = rising ? ChanW'(prod >> RiseShift) : ChanW'(prod >> FallShift);
    delta  = delta + 8'd1;
    if (now == goal) begin
      return now;
    end else if (rising) begin
      return now + delta;
    end else begin
      return now - delta;
    end
  endfunction

  function automatic rgb_t step_rgb(input rgb_t now, input rgb_t goal);
    rgb_t res;
    res.r = step_chan(now.r, goal.r);
    res.g = step_chan(now.g, goal.g);
    res.b = step_chan(now.b, goal.b);
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/lsfb_if.sv -----
// Handshake channel interfaces: command input, LED word output, register writes.
`default_nettype none

interface lsfb_in_if import lsfb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [IdxW-1:0]  led_index;
  logic [ChanW-1:0] red_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] blue_in;

  modport source (output valid, command, led_index, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, command, led_index, red_in, green_in, blue_in,
                  output ready);
endinterface

interface lsfb_out_if import lsfb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  out_index;
  logic [WordW-1:0] grb_word;
  logic             last;

  modport source (output valid, out_index, grb_word, last, input ready);
  modport sink   (input valid, out_index, grb_word, last, output ready);
endinterface

interface lsfb_cfg_if import lsfb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/led_strip_fade_breathe_refresh.sv -----
// A setpoint write is stored at its transfer and leaves the input ready; the first word
//   of a refresh passes the walk state register and then the output register.
// Throughput: one LED word per cycle while the output drains, set by the single read
//   port of the color memories; a refresh keeps the input not ready until the walk has
//   passed its last LED, also when the LED count is zero.
// Reset: control, registers and per-entry valid bits clear at once; no clearing pass.
`default_nettype none

module led_strip_fade_breathe_refresh import lsfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsfb_in_if.sink    in_i,
  lsfb_out_if.source out_o,
  lsfb_cfg_if.sink   cfg_i
);

  logic             fade_q;
  logic [CntW-1:0]  count_q;
  logic [AddrW-1:0] rd_addr;
  mem_wr_t          cur_wr;
  mem_wr_t          set_wr;
  rgb_t             cur_rd;
  rgb_t             set_rd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q  <= 1'b1;
      count_q <= ResetCount;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_FADE_ENABLE: fade_q <= cfg_i.data[0];
        REG_LED_COUNT: begin
          count_q <= (int'(cfg_i.data) > MaxLeds) ? CntW'(MaxLeds) : CntW'(cfg_i.data);
        end
        default: ;
      endcase
    end
  end

  lsfb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .fade_en_i   (fade_q),
    .led_count_i (count_q),
    .rd_addr_o   (rd_addr),
    .cur_wr_o    (cur_wr),
    .set_wr_o    (set_wr),
    .cur_rd_i    (cur_rd),
    .set_rd_i    (set_rd)
  );

  lsfb_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .cur_wr_i  (cur_wr),
    .set_wr_i  (set_wr),
    .cur_rd_o  (cur_rd),
    .set_rd_o  (set_rd)
  );

endmodule

`default_nettype wire

// ----- hdl/lsfb_mem.sv -----
// Current-color and setpoint memories with registered read and per-entry valid bits.
`default_nettype none

module lsfb_mem import lsfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AddrW-1:0] rd_addr_i,
  input  mem_wr_t          cur_wr_i,
  input  mem_wr_t          set_wr_i,
  output rgb_t             cur_rd_o,
  output rgb_t             set_rd_o
);

  rgb_t               cur_mem [MaxLeds];
  rgb_t               set_mem [MaxLeds];
  rgb_t               cur_dat_q;
  rgb_t               set_dat_q;
  logic [MaxLeds-1:0] cur_vld_q;
  logic [MaxLeds-1:0] set_vld_q;
  logic               cur_hit_q;
  logic               set_hit_q;

  always_ff @(posedge clk_i) begin
    if (cur_wr_i.en) begin
      cur_mem[cur_wr_i.addr] <= cur_wr_i.data;
    end
    if (set_wr_i.en) begin
      set_mem[set_wr_i.addr] <= set_wr_i.data;
    end
    cur_dat_q <= cur_mem[rd_addr_i];
    set_dat_q <= set_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= '0;
      set_vld_q <= '0;
      cur_hit_q <= 1'b0;
      set_hit_q <= 1'b0;
    end else begin
      if (cur_wr_i.en) begin
        cur_vld_q[cur_wr_i.addr] <= 1'b1;
      end
      if (set_wr_i.en) begin
        set_vld_q[set_wr_i.addr] <= 1'b1;
      end
      cur_hit_q <= cur_vld_q[rd_addr_i];
      set_hit_q <= set_vld_q[rd_addr_i];
    end
  end

  // never-written entries read as their reset color
  assign cur_rd_o = cur_hit_q ? cur_dat_q : '0;
  assign set_rd_o = set_hit_q ? set_dat_q : SetpointInit;

endmodule

`default_nettype wire

// ----- hdl/lsfb_seq.sv -----
// Command sequencer: setpoint writes, refresh walk with read-modify-write, output register.
`default_nettype none

module lsfb_seq import lsfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  lsfb_in_if.sink          in_i,
  lsfb_out_if.source       out_o,
  input  logic             fade_en_i,
  input  logic [CntW-1:0]  led_count_i,
  output logic [AddrW-1:0] rd_addr_o,
  output mem_wr_t          cur_wr_o,
  output mem_wr_t          set_wr_o,
  input  rgb_t             cur_rd_i,
  input  rgb_t             set_rd_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d, idx_nx;
  logic             tb_q, tb_d;
  logic             flip_q, flip_d;
  logic             out_vld_q, out_vld_d;
  logic [IdxW-1:0]  out_idx_q, out_idx_d;
  logic [WordW-1:0] out_word_q, out_word_d;
  logic             out_last_q, out_last_d;

  logic in_acc, walking, pass_empty, last_led, out_free, advance, done;
  logic at_goal, flip_now, flip_sel;
  rgb_t target, new_cur, chk;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign walking    = (state_q == ST_WALK);
  assign pass_empty = (led_count_i == '0);
  assign idx_nx     = idx_q + CntW'(1);
  assign last_led   = (idx_nx == led_count_i);
  assign out_free   = !out_vld_q || out_o.ready;
  assign advance    = walking && (pass_empty || out_free);
  assign done       = pass_empty || last_led;

  assign target  = tb_q ? '0 : set_rd_i;
  assign new_cur = fade_en_i ? step_rgb(cur_rd_i, target) : set_rd_i;

  // breathe check on LED 0; an empty pass checks the unchanged color
  assign chk      = pass_empty ? cur_rd_i : new_cur;
  assign at_goal  = (chk == target);
  assign flip_now = (fade_en_i && at_goal) ? (|chk) : tb_q;
  assign flip_sel = (idx_q == '0) ? flip_now : flip_q;

  // fetch the next entry while this one is written back
  assign rd_addr_o = advance ? idx_nx[AddrW-1:0] : idx_q[AddrW-1:0];

  assign cur_wr_o.en   = advance && !pass_empty;
  assign cur_wr_o.addr = idx_q[AddrW-1:0];
  assign cur_wr_o.data = new_cur;

  assign set_wr_o.en   = in_acc && (in_i.command == CMD_WRITE)
                         && (int'(in_i.led_index) < MaxLeds);
  assign set_wr_o.addr = AddrW'(in_i.led_index);
  assign set_wr_o.data = '{r: in_i.red_in, g: in_i.green_in, b: in_i.blue_in};

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    tb_d       = tb_q;
    flip_d     = flip_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_idx_d  = out_idx_q;
    out_word_d = out_word_q;
    out_last_d = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.command == CMD_REFRESH)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (advance) begin
          if (!pass_empty) begin
            out_vld_d  = 1'b1;
            out_idx_d  = IdxW'(idx_q);
            out_word_d = {new_cur.g, new_cur.r, new_cur.b};
            out_last_d = last_led;
          end
          if (idx_q == '0) begin
            flip_d = flip_now;
          end
          if (done) begin
            state_d = ST_IDLE;
            idx_d   = '0;
            tb_d    = flip_sel;
          end else begin
            idx_d = idx_nx;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      tb_q      <= 1'b0;
      flip_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      tb_q      <= tb_d;
      flip_q    <= flip_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q  <= out_idx_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_index = out_idx_q;
  assign out_o.grb_word  = out_word_q;
  assign out_o.last      = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/lsfb_chk.sv -----
// Port-level checks for the LED strip controller, bound to the top level.
`default_nettype none

module lsfb_chk import lsfb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_command_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IdxW-1:0]  out_index_i,
  input logic [WordW-1:0] out_word_i,
  input logic             out_last_i
);

  // a refresh always occupies the block past its transfer cycle
  a_refresh_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == CMD_REFRESH) |=> !in_ready_i)
    else $error("input ready right after a refresh transfer");

  // a setpoint write leaves the input ready in the cycle after its transfer
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == CMD_WRITE) |=> in_ready_i)
    else $error("input not ready after a setpoint write");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i)
                                    && $stable(out_word_i) && $stable(out_last_i))
    else $error("stalled LED word changed");

  // a word that directly follows a non-last word of a pass is never LED 0
  a_pass_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> !out_valid_i || (out_index_i != '0))
    else $error("LED word order broken inside a pass");

endmodule

bind led_strip_fade_breathe_refresh lsfb_chk u_lsfb_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_index_i  (out_o.out_index),
  .out_word_i   (out_o.grb_word),
  .out_last_i   (out_o.last)
);

`default_nettype wire
